@@ rtl/pbsd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the packbits scanline decoder
package pbsd_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int ROW_BYTE_BITS_DEF = 14;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [1:0] CFG_PIXEL_MODE     = 2'd0;
    localparam logic [1:0] CFG_ROW_BYTE_TOTAL = 2'd1;
    localparam logic [1:0] CFG_LINE_WIDTH     = 2'd2;

    localparam logic [13:0] PREFIX_SPLIT = 14'd250;

    typedef struct packed {
        logic       action;
        logic [7:0] stream_byte;
        logic [7:0] palette_slot;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [13:0] start_pixel;
        logic [7:0]  pixel_count;
        logic [13:0] row_number;
        logic        line_end;
        logic [15:0] line_byte_count;
    } out_word_t;

    typedef struct packed {
        logic        pixel_mode;
        logic [13:0] row_byte_total;
        logic [13:0] line_width;
    } cfg_t;

    typedef struct packed {
        logic        is_write;
        logic        direct;
        logic [15:0] unit;
        logic [13:0] fill_start;
        logic [7:0]  count;
        logic        line_end;
        logic [13:0] row;
        logic [15:0] prefix;
        logic [7:0]  slot;
        logic [23:0] rgb;
    } op_t;

endpackage

@@ rtl/packbits_scanline_decoder_top.sv @@
`timescale 1ns / 1ps
// top level of the packbits scanline decoder
//
// in channel: one word per handshake, either a compressed stream byte or a
// palette write (action high). out channel: one word per decoded run or
// literal unit, carrying colour, start pixel, clipped count, row number,
// line end flag and the line's byte-count prefix.
// config: cfg_write with cfg_index and cfg_data sets pixel mode, row byte
// total and line width; write only while the block is idle.
// throughput: one input word per cycle while in_ready is high. a result
// passes through the queue, the palette read stage and the output
// register before it is presented, and is held back further when the receiver stalls.
// a four-entry queue sits between the parser and the colour/clip stages;
// in_ready falls only when that queue is full, so a stalled receiver fills
// the output register, the read stage and then the queue before input stops.
// reset clears the parser, line counter, queue and output valid; palette
// contents are undefined until written and need no clearing.
module packbits_scanline_decoder_top #(
    parameter int PALETTE_DEPTH = pbsd_pkg::PALETTE_DEPTH_DEF,
    parameter int ROW_BYTE_BITS = pbsd_pkg::ROW_BYTE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pbsd_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pbsd_pkg::out_word_t out_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [13:0]         cfg_data
);
    import pbsd_pkg::*;

    localparam logic [13:0] RowMask = 14'((32'd1 << ROW_BYTE_BITS) - 32'd1);

    cfg_t cfg_reg, cfg_next;
    logic q_push;
    op_t  q_push_op;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    op_t  q_head_op;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PIXEL_MODE:     cfg_next.pixel_mode     = cfg_data[0];
                CFG_ROW_BYTE_TOTAL: cfg_next.row_byte_total = cfg_data & RowMask;
                CFG_LINE_WIDTH:     cfg_next.line_width     = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pbsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .push     (q_push),
        .push_op  (q_push_op),
        .q_full   (q_full)
    );

    pbsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    pbsd_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_op    (q_head_op),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ rtl/pbsd_front.sv @@
`timescale 1ns / 1ps
// front end: prefix and control byte parsing, run geometry, line tracking
module pbsd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pbsd_pkg::in_word_t in_data,
    input  pbsd_pkg::cfg_t   cfg,
    output logic             push,
    output pbsd_pkg::op_t    push_op,
    input  logic             q_full
);
    import pbsd_pkg::*;

    localparam logic [2:0] PH_PFX_A = 3'd0;
    localparam logic [2:0] PH_PFX_B = 3'd1;
    localparam logic [2:0] PH_CTRL  = 3'd2;
    localparam logic [2:0] PH_LIT_A = 3'd3;
    localparam logic [2:0] PH_LIT_B = 3'd4;
    localparam logic [2:0] PH_REP_A = 3'd5;
    localparam logic [2:0] PH_REP_B = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] prefix_reg, prefix_next;
    logic [13:0] filled_reg, filled_next;
    logic [7:0]  run_reg, run_next;
    logic [7:0]  held_reg, held_next;
    logic [13:0] line_reg, line_next;

    logic        accept;
    logic        em_direct;
    logic [7:0]  em_req;
    logic        has_room;
    logic [13:0] rem;
    logic [8:0]  req_bytes;
    logic        fills;
    logic [13:0] n_fit;
    logic [7:0]  em_count;
    logic [13:0] filled_after;
    logic        emit_go;
    logic [15:0] emit_unit;
    logic        start_line;
    logic        close_run;
    logic [13:0] filled_eff;
    logic [7:0]  byte_in;
    logic [13:0] total;

    assign accept   = in_valid && !q_full;
    assign in_ready = !q_full;
    assign byte_in  = in_data.stream_byte;
    assign total    = cfg.row_byte_total;

    // run geometry against the row bytes
    always_comb
    begin
        em_direct    = (phase_reg == PH_LIT_B) || (phase_reg == PH_REP_B);
        em_req       = ((phase_reg == PH_REP_A) || (phase_reg == PH_REP_B)) ? run_reg : 8'd1;
        has_room     = filled_reg < total;
        rem          = total - filled_reg;
        req_bytes    = em_direct ? {em_req, 1'b0} : {1'b0, em_req};
        fills        = {5'd0, req_bytes} >= rem;
        n_fit        = em_direct ? 14'((15'({1'b0, rem}) + 15'd1) >> 1) : rem;
        em_count     = fills ? n_fit[7:0] : em_req;
        filled_after = fills ? total : filled_reg + {5'd0, req_bytes};
    end

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        filled_next = filled_reg;
        run_next    = run_reg;
        held_next   = held_reg;
        line_next   = line_reg;
        emit_go     = 1'b0;
        emit_unit   = {8'h00, byte_in};
        start_line  = 1'b0;
        close_run   = 1'b0;
        filled_eff  = filled_reg;
        push        = 1'b0;
        push_op     = '0;

        if (accept)
        begin
            if (in_data.action)
            begin
                push             = 1'b1;
                push_op.is_write = 1'b1;
                push_op.slot     = in_data.palette_slot;
                push_op.rgb      = {in_data.palette_red, in_data.palette_green,
                                    in_data.palette_blue};
            end
            else
            begin
                case (phase_reg)
                    PH_PFX_A:
                    begin
                        if (total > PREFIX_SPLIT)
                        begin
                            held_next  = byte_in;
                            phase_next = PH_PFX_B;
                        end
                        else
                        begin
                            prefix_next = {8'h00, byte_in};
                            start_line  = 1'b1;
                        end
                    end
                    PH_PFX_B:
                    begin
                        prefix_next = {held_reg, byte_in};
                        start_line  = 1'b1;
                    end
                    PH_CTRL:
                    begin
                        if (!byte_in[7])
                        begin
                            run_next   = byte_in + 8'd1;
                            phase_next = PH_LIT_A;
                        end
                        else if (byte_in == 8'd128)
                        begin
                            close_run = 1'b1;
                        end
                        else
                        begin
                            run_next   = 8'(9'd257 - {1'b0, byte_in});
                            phase_next = PH_REP_A;
                        end
                    end
                    PH_LIT_A, PH_LIT_B:
                    begin
                        if (phase_reg == PH_LIT_A && cfg.pixel_mode)
                        begin
                            held_next  = byte_in;
                            phase_next = PH_LIT_B;
                        end
                        else
                        begin
                            emit_go   = 1'b1;
                            emit_unit = (phase_reg == PH_LIT_B) ? {held_reg, byte_in}
                                                                : {8'h00, byte_in};
                            run_next  = run_reg - 8'd1;
                            if (run_reg != 8'd1)
                                phase_next = PH_LIT_A;
                            else
                                close_run = 1'b1;
                        end
                    end
                    PH_REP_A:
                    begin
                        if (cfg.pixel_mode)
                        begin
                            held_next  = byte_in;
                            phase_next = PH_REP_B;
                        end
                        else
                        begin
                            emit_go   = 1'b1;
                            run_next  = 8'd0;
                            close_run = 1'b1;
                        end
                    end
                    PH_REP_B:
                    begin
                        emit_go   = 1'b1;
                        emit_unit = {held_reg, byte_in};
                        run_next  = 8'd0;
                        close_run = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_PFX_A;
                    end
                endcase

                if (emit_go && has_room)
                begin
                    filled_next        = filled_after;
                    filled_eff         = filled_after;
                    push               = 1'b1;
                    push_op.direct     = em_direct;
                    push_op.unit       = emit_unit;
                    push_op.fill_start = filled_reg;
                    push_op.count      = em_count;
                    push_op.line_end   = fills;
                    push_op.row        = line_reg;
                    push_op.prefix     = prefix_reg;
                end

                if (start_line)
                begin
                    filled_next = 14'd0;
                    run_next    = 8'd0;
                    if (total == 14'd0)
                    begin
                        line_next  = line_reg + 14'd1;
                        phase_next = PH_PFX_A;
                    end
                    else
                    begin
                        phase_next = PH_CTRL;
                    end
                end

                if (close_run)
                begin
                    if (filled_eff >= total)
                    begin
                        line_next  = line_reg + 14'd1;
                        phase_next = PH_PFX_A;
                    end
                    else
                    begin
                        phase_next = PH_CTRL;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PFX_A;
            prefix_reg <= 16'd0;
            filled_reg <= 14'd0;
            run_reg    <= 8'd0;
            held_reg   <= 8'd0;
            line_reg   <= 14'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            filled_reg <= filled_next;
            run_reg    <= run_next;
            held_reg   <= held_next;
            line_reg   <= line_next;
        end
    end

endmodule

@@ rtl/pbsd_queue.sv @@
`timescale 1ns / 1ps
// short first-in first-out queue of decoded operations
module pbsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pbsd_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pbsd_pkg::op_t head_op
);
    import pbsd_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    op_t              store_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == (QAW+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_op    = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/pbsd_back.sv @@
`timescale 1ns / 1ps
// back end: palette store, colour forming, pixel clipping and output register
module pbsd_back #(
    parameter int PALETTE_DEPTH = pbsd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pbsd_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  pbsd_pkg::op_t       head_op,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output pbsd_pkg::out_word_t out_data
);
    import pbsd_pkg::*;

    localparam int PIW = $clog2(PALETTE_DEPTH);

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] rd_reg;
    op_t         a_op_reg;
    logic        a_oob_reg;
    logic        a_valid_reg, a_valid_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    logic        out_load;
    logic        a_load;
    logic        slot_ok;
    logic        idx_oob;
    logic [13:0] start;
    logic [13:0] room;
    logic [7:0]  cnt;

    assign out_load = !out_valid_reg || out_ready;
    assign a_load   = !a_valid_reg || out_load;
    assign pop      = head_valid && a_load;
    assign slot_ok  = {1'b0, head_op.slot} < 9'(PALETTE_DEPTH);
    assign idx_oob  = {1'b0, head_op.unit[7:0]} >= 9'(PALETTE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (pop && head_op.is_write && slot_ok)
            pal_mem[head_op.slot[PIW-1:0]] <= head_op.rgb;
        if (pop && !head_op.is_write)
        begin
            rd_reg    <= pal_mem[head_op.unit[PIW-1:0]];
            a_op_reg  <= head_op;
            a_oob_reg <= idx_oob;
        end
    end

    always_comb
    begin
        a_valid_next   = a_load ? (head_valid && !head_op.is_write) : a_valid_reg;
        out_valid_next = out_load ? a_valid_reg : out_valid_reg;

        start = a_op_reg.direct ? {1'b0, a_op_reg.fill_start[13:1]} : a_op_reg.fill_start;
        room  = cfg.line_width - start;
        if (start >= cfg.line_width)
            cnt = 8'd0;
        else if (room < {6'd0, a_op_reg.count})
            cnt = room[7:0];
        else
            cnt = a_op_reg.count;

        if (a_op_reg.direct)
        begin
            out_next.out_red   = {3'b000, a_op_reg.unit[14:10]};
            out_next.out_green = {3'b000, a_op_reg.unit[9:5]};
            out_next.out_blue  = {3'b000, a_op_reg.unit[4:0]};
        end
        else if (a_oob_reg)
        begin
            out_next.out_red   = 8'h00;
            out_next.out_green = 8'h00;
            out_next.out_blue  = 8'h00;
        end
        else
        begin
            out_next.out_red   = rd_reg[23:16];
            out_next.out_green = rd_reg[15:8];
            out_next.out_blue  = rd_reg[7:0];
        end
        out_next.start_pixel     = start;
        out_next.pixel_count     = cnt;
        out_next.row_number      = a_op_reg.row;
        out_next.line_end        = a_op_reg.line_end;
        out_next.line_byte_count = a_op_reg.prefix;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && a_valid_reg)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/pbsd_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the packbits scanline decoder and their binding
module pbsd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input pbsd_pkg::out_word_t out_data
);
    import pbsd_pkg::*;

    // no word can be on the output during reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // the shortest path through queue, read stage and output register
    assert property (@(posedge clk) $rose(rst_n) |=> !out_valid)
        else $error("output valid too soon after reset");

    // a run never exceeds 128 pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.pixel_count <= 8'd128)
        else $error("pixel count above run limit");

    // a stalled word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

endmodule

bind packbits_scanline_decoder_top pbsd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
